### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, gated off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion on the default checker clock and reset.
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### rtl/pcsp_pkg.sv
// Types and constants of the PLL counter serial programmer.
`default_nettype none

package pcsp_pkg;

    // Synthesizer word widths
    localparam int REF_BITS = 14;
    localparam int N_BITS   = 10;
    localparam int A_BITS   = 7;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // Input request fields
    localparam int FREQ_W  = 20;
    localparam int SHIFT_W = 16;
    localparam int DIR_W   = 2;
    localparam int TUNE_W  = 32;

    // Shift direction codes (two's complement)
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'b00;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'b01;
    localparam logic [DIR_W-1:0] DIR_DOWN2 = 2'b10;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'b11;

    // Band type codes
    localparam logic BAND_VHF = 1'b0;
    localparam logic BAND_UHF = 1'b1;

    // Event kind codes
    localparam logic EV_DATA  = 1'b0;
    localparam logic EV_LATCH = 1'b1;

    // Receive IF offset and reference word
    localparam logic [TUNE_W-1:0]   IF_OFFSET_KHZ = 32'd45000;
    localparam logic [REF_BITS-1:0] REF_WORD      = 14'd1024;

    // n = f / 1000 = (f >> 3) / 125, reciprocal exact for 29-bit operands
    localparam int                RECIP125_SHIFT = 36;
    localparam logic [29:0]       RECIP125       = 30'd549755814;
    localparam logic [N_BITS-1:0] KHZ_PER_N      = 10'd1000;
    // a = floor(2r/25) = (r * 1311) >> 14 for r < 1000
    localparam int                RECIP25_SHIFT  = 14;
    localparam logic [10:0]       RECIP25        = 11'd1311;

    // Event sequence: ref word, ctl 1, latch, N, A, ctl 0, final latch
    localparam int            EV_COUNT    = REF_BITS + N_BITS + A_BITS + 4;
    localparam int            CNT_W       = $clog2(EV_COUNT);
    localparam logic [CNT_W-1:0] EV_LATCH1 = CNT_W'(REF_BITS + 1);
    localparam logic [CNT_W-1:0] EV_FINAL  = CNT_W'(EV_COUNT - 1);

    // Command handed from the front to the serializer
    typedef struct packed {
        logic [1:0]        band;
        logic [N_BITS-1:0] n;
        logic [A_BITS-1:0] a;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/pcsp_front.sv
// Front end: accepts requests, updates the band, computes N and A.
`default_nettype none

module pcsp_front
    import pcsp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [IN_USER_W-1:0] s_axis_tuser,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_cmd                      o_cmd
);

    logic                 r_band_type;
    logic [1:0]           r_band;
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [TUNE_W-1:0]    r_f1;
    logic [1:0]           r_band1, r_band2, r_band3, r_band4;
    logic [58:0]          r_p2;
    logic [9:0]           r_flo2;
    logic [N_BITS-1:0]    r_n3, r_n4;
    logic [9:0]           r_r3;
    logic [A_BITS-1:0]    r_a4;

    logic                 w_advance, w_accept, w_take;
    logic [FREQ_W-1:0]    w_freq;
    logic [SHIFT_W-1:0]   w_shift;
    logic [DIR_W-1:0]     w_dir;
    logic                 w_tx;
    logic [1:0]           w_band_next;
    logic [TUNE_W-1:0]    w_tuned;
    logic [N_BITS-1:0]    w_n;
    logic [19:0]          w_nk;
    logic [20:0]          w_ar;

    // Unpack request fields
    assign w_freq  = s_axis_tdata[FREQ_W-1:0];
    assign w_shift = s_axis_tdata[FREQ_W+SHIFT_W-1:FREQ_W];
    assign w_dir   = s_axis_tdata[FREQ_W+SHIFT_W+DIR_W-1:FREQ_W+SHIFT_W];
    assign w_tx    = s_axis_tuser[1];

    // Stall the whole pipe only when the last stage cannot push
    assign w_advance     = !(r_v4 && i_full);
    assign s_axis_tready = w_advance;
    assign w_accept      = s_axis_tvalid && w_advance;
    assign w_take        = w_accept && s_axis_tuser[0];
    assign o_push        = r_v4 && !i_full;

    // Band select update; no matching range keeps the old value
    always_comb begin
        w_band_next = r_band;
        if (r_band_type == BAND_VHF) begin
            if (w_freq inside {[20'd164000:20'd173999]}) begin
                w_band_next = 2'd0;
            end else if (w_freq inside {[20'd154000:20'd163999]}) begin
                w_band_next = 2'd2;
            end else if (w_freq inside {[20'd146000:20'd153999]}) begin
                w_band_next = 2'd1;
            end else if (w_freq inside {[20'd134000:20'd145999]}) begin
                w_band_next = 2'd3;
            end
        end else begin
            if (w_freq inside {[20'd452000:20'd469999]}) begin
                w_band_next = 2'd0;
            end else if (w_freq inside {[20'd430000:20'd451999]}) begin
                w_band_next = 2'd3;
            end
        end
    end

    // Tuned frequency, modulo 2^32
    always_comb begin
        w_tuned = TUNE_W'(w_freq);
        if (!w_tx) begin
            if (r_band_type == BAND_VHF) begin
                w_tuned = TUNE_W'(w_freq) + IF_OFFSET_KHZ;
            end else begin
                w_tuned = TUNE_W'(w_freq) - IF_OFFSET_KHZ;
            end
        end else begin
            case (w_dir)
                DIR_UP:    w_tuned = TUNE_W'(w_freq) + TUNE_W'(w_shift);
                DIR_DOWN:  w_tuned = TUNE_W'(w_freq) - TUNE_W'(w_shift);
                DIR_DOWN2: w_tuned = TUNE_W'(w_freq) - {15'd0, w_shift, 1'b0};
                default:   w_tuned = TUNE_W'(w_freq);
            endcase
        end
    end

    // N low bits, remainder of f / 1000, and A = floor(2r / 25)
    assign w_n  = r_p2[RECIP125_SHIFT+N_BITS-1:RECIP125_SHIFT];
    assign w_nk = w_n * KHZ_PER_N;
    assign w_ar = r_r3 * RECIP25;

    // Control state: config, band, stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_type <= BAND_VHF;
            r_band      <= 2'd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_band_type <= i_cfg_wdata;
            end
            if (w_take) begin
                r_band <= w_band_next;
            end
            if (w_advance) begin
                r_v1 <= w_take;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end
        end
    end

    // Arithmetic pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_f1    <= w_tuned;
            r_band1 <= w_band_next;
            r_p2    <= r_f1[TUNE_W-1:3] * RECIP125;
            r_flo2  <= r_f1[9:0];
            r_band2 <= r_band1;
            r_n3    <= w_n;
            r_r3    <= r_flo2 - w_nk[9:0];
            r_band3 <= r_band2;
            r_n4    <= r_n3;
            r_a4    <= w_ar[RECIP25_SHIFT+A_BITS-1:RECIP25_SHIFT];
            r_band4 <= r_band3;
        end
    end

    assign o_cmd.band = r_band4;
    assign o_cmd.n    = r_n4;
    assign o_cmd.a    = r_a4;

endmodule

`default_nettype wire

### rtl/pcsp_queue.sv
// Command queue between the front end and the serializer.
`default_nettype none

module pcsp_queue
    import pcsp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_full,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    t_cmd           r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/pcsp_serializer.sv
// Back end: walks one command through its 35 serial events.
`default_nettype none

module pcsp_serializer
    import pcsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  t_cmd                       i_head,
    input  wire logic                  i_empty,
    output logic                       o_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    output logic                       m_axis_tuser
);

    logic [CNT_W-1:0]    r_cnt;
    logic                r_valid;
    logic                r_kind, r_bit, r_last;
    logic [1:0]          r_band;

    logic                w_load;
    logic [EV_COUNT-1:0] w_bits;
    logic [CNT_W-1:0]    w_idx;

    // Full bit sequence, first event in the top bit; latch slots are zero
    assign w_bits = {REF_WORD, 1'b1, 1'b0, i_head.n, i_head.a, 1'b0, 1'b0};
    assign w_idx  = EV_FINAL - r_cnt;

    assign w_load = !i_empty && (!r_valid || m_axis_tready);
    assign o_pop  = w_load && (r_cnt == EV_FINAL);

    // Event counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_cnt   <= (r_cnt == EV_FINAL) ? '0 : r_cnt + 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output event register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= (r_cnt == EV_LATCH1 || r_cnt == EV_FINAL) ? EV_LATCH : EV_DATA;
            r_bit  <= w_bits[w_idx];
            r_last <= (r_cnt == EV_FINAL);
            r_band <= i_head.band;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_band, r_bit};
    assign m_axis_tlast  = r_last;
    assign m_axis_tuser  = r_kind;

endmodule

`default_nettype wire

### rtl/pll_counter_serial_programmer_top.sv
// Top level of the PLL counter serial programmer.
//
// Input stream (s_axis): one channel request per transfer. Requests with
// the valid flag low are taken and dropped. Each valid request updates the
// kept band select and is turned into the N and A counter values by a
// four-stage arithmetic pipe (reciprocal multiplies by 1/125 and 2/25).
// Output stream (m_axis): 35 serial events per valid request, one per
// cycle while the receiver is ready: 14 reference bits, control 1, latch,
// 10 N bits, 7 A bits, control 0, final latch (tlast). tuser is the event
// kind. The serializer sets the request rate; the front keeps accepting
// into a QUEUE_DEPTH command queue while the serializer runs, and only
// stalls when that queue is full and the last pipe stage holds a command.
// A receiver stall holds the current event and backs up the queue.
// band_type is written through i_cfg_we/i_cfg_wdata only while the block
// idles; the user must keep to this, as the block has no check for it.
// Reset (i_rst_n low, synchronous) clears the band select, band_type,
// the queue and all pipeline valids.
`default_nettype none

module pll_counter_serial_programmer_top
    import pcsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [19:0] frequency_khz, [35:20] shift_khz, [37:36] shift_direction
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] frequency_valid, [1] transmit
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] data_bit, [2:1] band_select
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    // [0] event_kind
    output logic                       m_axis_tuser
);

    t_cmd w_push_cmd, w_head;
    logic w_push, w_pop, w_full, w_empty;

    pcsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    pcsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pcsp_serializer u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

### rtl/pcsp_checker.sv
// Port-level checker for the PLL counter serial programmer, with its bind.
`default_nettype none
`include "assert_macros.svh"

module pcsp_checker
    import pcsp_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic                  m_axis_tuser
);

    logic                  w_stall, w_step, w_final, w_latch;
    logic [OUT_DATA_W+1:0] w_ev;
    logic [1:0]            w_band;

    // Port views used by the assertions
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_step  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
    assign w_final = m_axis_tvalid && m_axis_tlast;
    assign w_latch = m_axis_tvalid && (m_axis_tuser == EV_LATCH);
    assign w_ev    = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
    assign w_band  = m_axis_tdata[2:1];

    // A stalled event holds
    `ASSERT_STD(a_hold, w_stall |=> m_axis_tvalid && $stable(w_ev), "stalled event changed")
    // The final event is a latch pulse
    `ASSERT_STD(a_last_latch, w_final |-> m_axis_tuser == EV_LATCH, "tlast on a data event")
    // Latch pulses carry a zero data bit
    `ASSERT_STD(a_latch_zero, w_latch |-> !m_axis_tdata[0], "latch with data bit set")
    // Within a sequence events follow back to back with one band select
    `ASSERT_STD(a_band_run, w_step |=> m_axis_tvalid && $stable(w_band), "sequence broken")

endmodule

bind pll_counter_serial_programmer_top pcsp_checker u_pcsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### bench/tb_pll_counter_serial_programmer_top.sv
// Self-checking testbench for the PLL counter serial programmer top level.
module tb_pll_counter_serial_programmer_top
    import pcsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PRESCALE  = 80;
    localparam int          SETTLE    = 20;
    localparam int          TAIL      = 50;
    localparam int          RX_HOLD   = 400;
    localparam int          PHASES    = 7;
    localparam int          PHASE_LEN = 14;
    localparam int          N_ROWS    = 25;
    localparam int unsigned LIMIT     = 1000000;

    // One channel request as it enters the block
    typedef struct packed {
        logic               valid;
        logic               tx;
        logic [DIR_W-1:0]   dir;
        logic [SHIFT_W-1:0] shift;
        logic [FREQ_W-1:0]  freq;
    } t_chan_req;

    // One serial event as it leaves the block
    typedef struct packed {
        logic       kind;
        logic       dbit;
        logic [1:0] sel;
        logic       last;
    } t_serial_ev;

    // Directed row: band type, request, and a pinned band select where obvious
    typedef struct packed {
        logic               band;
        logic               valid;
        logic               tx;
        logic [DIR_W-1:0]   dir;
        logic [SHIFT_W-1:0] shift;
        logic [FREQ_W-1:0]  freq;
        logic               pin;
        logic [1:0]         sel;
    } t_dir_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic                  i_cfg_wdata   = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    // Predictor state and the events still owed by the block
    logic        band_cfg = BAND_VHF;
    logic [1:0]  band_sel_model = 2'd0;
    t_serial_ev  pending_events[$];
    int          err_count = 0;
    int unsigned cycles = 0;
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          rx_wait = 0;
    int          rx_tick = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    t_dir_row dir_rows [N_ROWS] = '{
        '{BAND_VHF, 1'b0, 1'b0, DIR_NONE,  16'd0,     20'd0,      1'b0, 2'd0},
        '{BAND_VHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd0,      1'b1, 2'd0},
        '{BAND_VHF, 1'b1, 1'b1, DIR_UP,    16'hFFFF,  20'hFFFFF,  1'b1, 2'd0},
        '{BAND_VHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd164000, 1'b1, 2'd0},
        '{BAND_VHF, 1'b1, 1'b1, DIR_NONE,  16'hFFFF,  20'd173999, 1'b1, 2'd0},
        '{BAND_VHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd174000, 1'b1, 2'd0},
        '{BAND_VHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd154000, 1'b1, 2'd2},
        '{BAND_VHF, 1'b1, 1'b1, DIR_DOWN,  16'd600,   20'd163999, 1'b1, 2'd2},
        '{BAND_VHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd146000, 1'b1, 2'd1},
        '{BAND_VHF, 1'b1, 1'b1, DIR_DOWN2, 16'hFFFF,  20'd153999, 1'b1, 2'd1},
        '{BAND_VHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd134000, 1'b1, 2'd3},
        '{BAND_VHF, 1'b1, 1'b1, DIR_UP,    16'd600,   20'd145999, 1'b1, 2'd3},
        '{BAND_VHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd133999, 1'b1, 2'd3},
        '{BAND_VHF, 1'b0, 1'b1, DIR_DOWN2, 16'hFFFF,  20'hFFFFF,  1'b0, 2'd0},
        '{BAND_VHF, 1'b1, 1'b1, DIR_DOWN,  16'hFFFF,  20'd0,      1'b1, 2'd3},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd452000, 1'b1, 2'd0},
        '{BAND_UHF, 1'b1, 1'b1, DIR_UP,    16'd5000,  20'd469999, 1'b1, 2'd0},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd470000, 1'b1, 2'd0},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd430000, 1'b1, 2'd3},
        '{BAND_UHF, 1'b1, 1'b1, DIR_DOWN,  16'd5000,  20'd451999, 1'b1, 2'd3},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd429999, 1'b1, 2'd3},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd0,      1'b1, 2'd3},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd44999,  1'b1, 2'd3},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd45000,  1'b1, 2'd3},
        '{BAND_UHF, 1'b1, 1'b0, DIR_NONE,  16'd0,     20'd150000, 1'b1, 2'd3}
    };

    pll_counter_serial_programmer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queue one serial event
    function automatic void push_event(logic kind, logic dbit, logic [1:0] sel, logic last);
        t_serial_ev ev;
        ev.kind = kind;
        ev.dbit = dbit;
        ev.sel  = sel;
        ev.last = last;
        pending_events.push_back(ev);
    endfunction

    // Queue a word as data bits, MSB first
    function automatic void push_word(logic [63:0] word, int bits, logic [1:0] sel);
        for (int i = bits - 1; i >= 0; i--)
            push_event(EV_DATA, word[i], sel, 1'b0);
    endfunction

    // Update the band select, tune, split into N and A, and queue the sequence
    function automatic void predict_program(t_chan_req r, bit pin, logic [1:0] pin_sel);
        logic [31:0] f;
        logic [63:0] steps;
        logic [63:0] n_cnt;
        logic [63:0] a_cnt;
        logic [1:0]  sel;
        if (!r.valid)
            return;
        f = 32'(r.freq);
        if (band_cfg == BAND_VHF) begin
            if (f < 174000 && f >= 164000)      band_sel_model = 2'd0;
            else if (f < 164000 && f >= 154000) band_sel_model = 2'd2;
            else if (f < 154000 && f >= 146000) band_sel_model = 2'd1;
            else if (f < 146000 && f >= 134000) band_sel_model = 2'd3;
        end else begin
            if (f < 470000 && f >= 452000)      band_sel_model = 2'd0;
            else if (f < 452000 && f >= 430000) band_sel_model = 2'd3;
        end
        if (!r.tx) begin
            f = (band_cfg == BAND_VHF) ? f + IF_OFFSET_KHZ : f - IF_OFFSET_KHZ;
        end else begin
            case (r.dir)
                DIR_UP:    f = f + 32'(r.shift);
                DIR_DOWN:  f = f - 32'(r.shift);
                DIR_DOWN2: f = f - (32'(r.shift) << 1);
                default: ;
            endcase
        end
        steps = ({32'd0, f} << 1) / 64'd25;
        n_cnt = steps / PRESCALE;
        a_cnt = steps % PRESCALE;
        sel   = pin ? pin_sel : band_sel_model;
        push_word(64'(REF_WORD), REF_BITS, sel);
        push_event(EV_DATA, 1'b1, sel, 1'b0);
        push_event(EV_LATCH, 1'b0, sel, 1'b0);
        push_word(n_cnt & ((64'd1 << N_BITS) - 1), N_BITS, sel);
        push_word(a_cnt, A_BITS, sel);
        push_event(EV_DATA, 1'b0, sel, 1'b0);
        push_event(EV_LATCH, 1'b0, sel, 1'b1);
    endfunction

    // Offer one request after a random gap; predict it at the accepting edge
    task automatic offer(t_chan_req r, bit pin, logic [1:0] pin_sel);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (tx_calm || pick < 60) gap = 0;
        else if (pick < 92)       gap = $urandom_range(1, 3);
        else                      gap = $urandom_range(8, 30);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.dir, r.shift, r.freq};
        s_axis_tuser  <= {r.tx, r.valid};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_program(r, pin, pin_sel);
    endtask

    // Hold off until every owed event is out, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write band_type while the block is idle
    task automatic write_band(logic band);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= band;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        band_cfg     = band;
    endtask

    // Pick a frequency: band edges, in-band values, or anything in 20 bits
    function automatic logic [FREQ_W-1:0] pick_freq(logic band);
        logic [FREQ_W-1:0] edges [20] = '{
            20'd133999, 20'd134000, 20'd145999, 20'd146000, 20'd153999,
            20'd154000, 20'd163999, 20'd164000, 20'd173999, 20'd174000,
            20'd429999, 20'd430000, 20'd451999, 20'd452000, 20'd469999,
            20'd470000, 20'd0,      20'd44999,  20'd45000,  20'hFFFFF
        };
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return FREQ_W'($urandom);
        else if (pick < 5)
            return edges[$urandom_range(0, 19)];
        else if (band == BAND_VHF)
            return FREQ_W'($urandom_range(134000, 173999));
        else
            return FREQ_W'($urandom_range(430000, 469999));
    endfunction

    // Receiver: check each accepted event, then choose the next ready
    always @(posedge i_clk) begin
        t_serial_ev want;
        int pick;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_pll_counter_serial_programmer_top NOT OK");
            $finish;
        end else if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_events.size() == 0) begin
                    $error("event with nothing owed: kind %0d bit %0d", m_axis_tuser,
                           m_axis_tdata[0]);
                    err_count++;
                end else begin
                    want = pending_events.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                        err_count++;
                    end
                    if (m_axis_tdata[0] !== want.dbit) begin
                        $error("data_bit: expected %0d, got %0d", want.dbit, m_axis_tdata[0]);
                        err_count++;
                    end
                    if (m_axis_tdata[2:1] !== want.sel) begin
                        $error("band_select: expected %0d, got %0d", want.sel,
                               m_axis_tdata[2:1]);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            // Flip between stalling and steady stretches now and then
            rx_tick++;
            if (rx_tick % 500 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_seen != hold_asks) begin
                hold_seen     = hold_asks;
                rx_wait       = RX_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                pick = rx_calm ? 99 : $urandom_range(0, 99);
                if (pick < 20) begin
                    rx_wait       = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else if (pick < 22) begin
                    rx_wait       = $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain
    initial begin
        t_chan_req req;
        t_dir_row  row;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_band(BAND_VHF);

        // Directed table
        for (int i = 0; i < N_ROWS; i++) begin
            row = dir_rows[i];
            if (row.band != band_cfg)
                write_band(row.band);
            req.valid = row.valid;
            req.tx    = row.tx;
            req.dir   = row.dir;
            req.shift = row.shift;
            req.freq  = row.freq;
            offer(req, row.pin, row.sel);
        end

        // Random phases, alternating band type
        for (int p = 0; p < PHASES; p++) begin
            write_band((p % 2 == 0) ? BAND_VHF : BAND_UHF);
            tx_calm = (p == 1) || ($urandom_range(0, 3) == 0);
            // Stall the receiver for a long stretch while requests keep coming
            if (p == 1)
                hold_asks <= hold_asks + 1;
            for (int k = 0; k < PHASE_LEN; k++) begin
                // Pause the sender until every owed event has come
                if (p == 3 && k == PHASE_LEN / 2)
                    wait_drained();
                req.valid = ($urandom_range(0, 99) < 85);
                req.tx    = $urandom_range(0, 1);
                req.dir   = DIR_W'($urandom);
                req.shift = SHIFT_W'($urandom);
                req.freq  = pick_freq(band_cfg);
                offer(req, 1'b0, 2'd0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (err_count == 0 && pending_events.size() == 0)
            $display("tb_pll_counter_serial_programmer_top OK");
        else
            $display("tb_pll_counter_serial_programmer_top NOT OK");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/pcsp_pkg.sv
rtl/pcsp_front.sv
rtl/pcsp_queue.sv
rtl/pcsp_serializer.sv
rtl/pll_counter_serial_programmer_top.sv
rtl/pcsp_checker.sv
bench/tb_pll_counter_serial_programmer_top.sv
